// ===== hw/rtl/sfr_pkg.sv =====
// Shared constants and types for the sync frame receiver.
package sfr_pkg;

    // Gap timer counter width (range 8 to 32).
    localparam int GAP_TIMER_BITS = 24;

    localparam int BYTE_W      = 8;
    localparam int GAP_LIMIT_W = 24;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 1;
    localparam int RESULT_W    = 3 * BYTE_W;
    localparam int CMP_W       = (GAP_TIMER_BITS > GAP_LIMIT_W) ? GAP_TIMER_BITS : GAP_LIMIT_W;

    localparam logic [BYTE_W-1:0]      SYNC_RESET      = 8'h24;
    localparam logic [GAP_LIMIT_W-1:0] GAP_LIMIT_RESET = 24'd8000000;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_VALUE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP_LIMIT  = 1'b1;

    // Input item kinds carried on tuser.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Frame position, one-hot.
    typedef enum logic [4:0] {
        ST_SYNC = 5'b00001,
        ST_CMD  = 5'b00010,
        ST_ARG1 = 5'b00100,
        ST_ARG2 = 5'b01000,
        ST_SUM  = 5'b10000
    } frame_state_t;

endpackage

// ===== hw/rtl/sync_frame_receiver_with_timeout_core.sv =====
// Sync byte frame receiver with additive checksum and inter-byte gap timeout.
//
// Input stream (s_*): each transfer is either a received byte (s_tuser low,
// byte in s_tdata) or one tick of the gap timer (s_tuser high, s_tdata unused).
// A frame is five bytes: sync, command, first argument, second argument and
// checksum (8-bit wrapping sum of the first four). A frame with a good
// checksum yields one transfer on the result stream (m_*); a bad one is
// dropped. While a frame is open, ticks advance a saturating gap counter; if
// it has reached gap_limit when the command or an argument byte arrives, that
// byte is dropped and the receiver goes back to hunting for sync. The
// checksum byte is never timed out.
//
// Configuration (cfg_*): index 0 writes sync_value, index 1 writes gap_limit.
// cfg_ready is always high; write only while the stream is idle.
// Timing: one input register and one result register. A result reaches m_*
// once its checksum byte has passed both; one item is taken every cycle
// unless the input stage stalls, which it does only while it holds a
// completed frame and the result register is still full, so a stalled
// receiver holds the result and backs up s_tready; ticks and other bytes keep
// flowing past a waiting result. Synchronous active-low reset restores the
// register defaults, empties both stages and returns to sync hunting.
module sync_frame_receiver_with_timeout_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [sfr_pkg::BYTE_W-1:0]           s_tdata,  // [7:0] byte_value
    input  logic                                 s_tuser,  // [0] kind
    // Result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [7:0] command, [15:8] first_arg, [23:16] second_arg
    output logic [sfr_pkg::RESULT_W-1:0]         m_tdata,
    // Configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sfr_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]       cfg_data
);

    // Configuration registers
    logic [sfr_pkg::BYTE_W-1:0]      sync_value_reg;
    logic [sfr_pkg::GAP_LIMIT_W-1:0] gap_limit_reg;

    // Input stage
    logic                            in_valid_reg;
    logic                            in_kind_reg;
    logic [sfr_pkg::BYTE_W-1:0]      in_byte_reg;

    // Frame state
    sfr_pkg::frame_state_t           state_reg, state_next;
    logic [sfr_pkg::BYTE_W-1:0]      sum_reg, sum_next;
    logic [sfr_pkg::BYTE_W-1:0]      cmd_reg, arg1_reg, arg2_reg;
    logic [sfr_pkg::GAP_TIMER_BITS-1:0] gap_count_reg, gap_count_next;
    logic                            expired_reg, expired_next;

    // Result stage
    logic                            out_valid_reg;
    logic [sfr_pkg::RESULT_W-1:0]    out_data_reg;

    logic                            frame_ok;
    logic                            advance;
    logic [sfr_pkg::GAP_TIMER_BITS-1:0] gap_inc;

    assign cfg_ready = 1'b1;
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // A good checksum byte completes a frame.
    assign frame_ok = in_valid_reg && (in_kind_reg == sfr_pkg::KIND_BYTE)
                      && (state_reg == sfr_pkg::ST_SUM) && (sum_reg == in_byte_reg);

    // Hold the stage only when its result has nowhere to go.
    assign advance = in_valid_reg && (!frame_ok || !out_valid_reg || m_tready);

    // Saturating increment of the gap counter.
    assign gap_inc = (&gap_count_reg) ? gap_count_reg : gap_count_reg + 1'b1;

    always_comb begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        gap_count_next = gap_count_reg;
        expired_next   = expired_reg;
        if (in_kind_reg == sfr_pkg::KIND_TICK) begin
            // Timer runs only while a frame is open.
            if (state_reg != sfr_pkg::ST_SYNC) begin
                gap_count_next = gap_inc;
                if (sfr_pkg::CMP_W'(gap_inc) >= sfr_pkg::CMP_W'(gap_limit_reg)) begin
                    expired_next = 1'b1;
                end
            end
        end else begin
            // Every byte restarts the gap timer; the timeout test uses the old flag.
            gap_count_next = '0;
            expired_next   = 1'b0;
            case (state_reg)
                sfr_pkg::ST_CMD, sfr_pkg::ST_ARG1, sfr_pkg::ST_ARG2: begin
                    if (expired_reg) begin
                        state_next = sfr_pkg::ST_SYNC;
                    end else begin
                        sum_next = sum_reg + in_byte_reg;
                        case (state_reg)
                            sfr_pkg::ST_CMD:  state_next = sfr_pkg::ST_ARG1;
                            sfr_pkg::ST_ARG1: state_next = sfr_pkg::ST_ARG2;
                            default:          state_next = sfr_pkg::ST_SUM;
                        endcase
                    end
                end
                sfr_pkg::ST_SUM: begin
                    // Pass or fail, the frame ends here.
                    state_next = sfr_pkg::ST_SYNC;
                end
                default: begin
                    if (in_byte_reg == sync_value_reg) begin
                        sum_next   = in_byte_reg;
                        state_next = sfr_pkg::ST_CMD;
                    end else begin
                        state_next = sfr_pkg::ST_SYNC;
                    end
                end
            endcase
        end
    end

    // Configuration, input stage, frame control and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_value_reg <= sfr_pkg::SYNC_RESET;
            gap_limit_reg  <= sfr_pkg::GAP_LIMIT_RESET;
            in_valid_reg   <= 1'b0;
            state_reg      <= sfr_pkg::ST_SYNC;
            sum_reg        <= '0;
            gap_count_reg  <= '0;
            expired_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    sfr_pkg::REG_SYNC_VALUE: sync_value_reg <= cfg_data[sfr_pkg::BYTE_W-1:0];
                    sfr_pkg::REG_GAP_LIMIT:  gap_limit_reg  <= cfg_data[sfr_pkg::GAP_LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                state_reg     <= state_next;
                sum_reg       <= sum_next;
                gap_count_reg <= gap_count_next;
                expired_reg   <= expired_next;
            end
            if (advance && frame_ok) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_kind_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (advance && (in_kind_reg == sfr_pkg::KIND_BYTE) && !expired_reg) begin
            case (state_reg)
                sfr_pkg::ST_CMD:  cmd_reg  <= in_byte_reg;
                sfr_pkg::ST_ARG1: arg1_reg <= in_byte_reg;
                sfr_pkg::ST_ARG2: arg2_reg <= in_byte_reg;
                default: ;
            endcase
        end
        if (advance && frame_ok) begin
            out_data_reg <= {arg2_reg, arg1_reg, cmd_reg};
        end
    end

    // Frame position stays one-hot.
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("frame state not one-hot");

    // The gap timer is idle while hunting for sync.
    a_timer_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sfr_pkg::ST_SYNC) |-> (gap_count_reg == '0) && !expired_reg)
        else $error("gap timer running outside a frame");

    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !(advance && frame_ok))
        else $error("result overwritten before transfer");

    // A completed frame returns the receiver to sync hunting.
    a_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && frame_ok) |=> (state_reg == sfr_pkg::ST_SYNC) && out_valid_reg)
        else $error("frame end not handled");

endmodule
